// ----- rtl/core/nsf_pkg.sv -----
// nsf_pkg: types and constants shared by the NMEA sentence framer.
// No dependencies; the framer top level takes these by scoped name.

package nsf_pkg;

    // Request kinds carried on the slave-side tuser
    typedef enum logic [1:0] {
        REQ_BYTE     = 2'd0,
        REQ_CLR_SENT = 2'd1,
        REQ_CLR_FAIL = 2'd2,
        REQ_READ     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_WAIT    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_READY   = 2'd2
    } t_frame_mode;

    localparam int unsigned BUF_DEPTH_DEF = 128;
    localparam int unsigned END_RESERVE   = 2;

    localparam logic [7:0] START_CHAR = 8'h24;
    localparam logic [7:0] LINE_END   = 8'h0A;

    localparam int unsigned IDX_W = 7;
    localparam int unsigned LEN_W = 7;
    localparam int unsigned CHR_W = 8;

endpackage

// ----- rtl/core/nsf_ram.sv -----
// nsf_ram: generic single-write, single-read RAM with registered read data.
// Read data holds its last value while no read is issued. No dependencies.

module nsf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/nmea_sentence_framer.sv -----
// Channel   Dir  Handshake              Payload
// s (req)   in   i_s_tvalid/o_s_tready  tdata: rx_byte, read_index; tuser: req_type
// m (res)   out  o_m_tvalid/i_m_tready  tdata: sentence_length, read_char;
//                                       tuser: sentence_ready, fail_flag
//
// One word is taken per cycle while m does not stall; each word's result passes through
// the read stage (registered line store read) and then the output register.
// Mode, fail flag and fill count update in the accept cycle; the line store
// gets at most one write per word, so no two words contend for it.
// Reset (i_rst_n low, synchronous) empties the pipe and returns to waiting.
// Back-pressure on m stalls the read stage and then the input.
// Depends on nsf_pkg and nsf_ram.

module nmea_sentence_framer #(
    parameter int unsigned BUF_DEPTH = nsf_pkg::BUF_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [7:0] rx_byte, [14:8] read_index, [15] zero
    input  logic [1:0]  i_s_tuser,   // [1:0] req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [6:0] sentence_length, [14:7] read_char, [15] zero
    output logic [1:0]  o_m_tuser    // [0] sentence_ready, [1] fail_flag
);

    localparam int unsigned CW   = $clog2(BUF_DEPTH);
    localparam int unsigned CMPW = (CW > nsf_pkg::IDX_W) ? CW : nsf_pkg::IDX_W;
    localparam logic [CW-1:0] FULL_AT = CW'(BUF_DEPTH - nsf_pkg::END_RESERVE);

    // control state
    nsf_pkg::t_frame_mode r_mode, n_mode;
    logic                 r_err, n_err;
    logic [CW-1:0]        r_count, n_count;

    // request decode
    nsf_pkg::t_req               req;
    logic [7:0]                  rx_byte;
    logic [nsf_pkg::IDX_W-1:0]   rd_idx;
    logic                        accept;

    // line store port
    logic          we;
    logic [CW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [7:0]    rdata;

    // read stage
    logic                       r_s1_vld;
    logic                       r_s1_ready;
    logic                       r_s1_fail;
    logic [nsf_pkg::LEN_W-1:0]  r_s1_len;
    logic                       r_s1_hit;
    logic                       s1_move;
    logic                       rd_hit;

    // output register
    logic                       r_out_vld;
    logic                       r_out_ready;
    logic                       r_out_fail;
    logic [nsf_pkg::LEN_W-1:0]  r_out_len;
    logic [nsf_pkg::CHR_W-1:0]  r_out_chr;

    assign req     = nsf_pkg::t_req'(i_s_tuser);
    assign rx_byte = i_s_tdata[7:0];
    assign rd_idx  = i_s_tdata[14:8];

    assign s1_move    = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_s1_vld || s1_move;
    assign accept     = i_s_tvalid && o_s_tready;

    // next mode, flag, count and line store write
    always_comb begin
        n_mode  = r_mode;
        n_err   = r_err;
        n_count = r_count;
        we      = 1'b0;
        waddr   = r_count;
        wdata   = rx_byte;
        if (accept) begin
            case (req)
                nsf_pkg::REQ_BYTE: begin
                    case (r_mode)
                        nsf_pkg::MODE_COLLECT: begin
                            if (r_count >= FULL_AT) begin
                                // overflow: drop the byte and start over
                                n_err   = 1'b1;
                                n_count = '0;
                                n_mode  = nsf_pkg::MODE_WAIT;
                            end else if (rx_byte == nsf_pkg::START_CHAR) begin
                                we      = 1'b1;
                                waddr   = '0;
                                wdata   = nsf_pkg::START_CHAR;
                                n_count = CW'(1);
                                n_err   = 1'b1;
                            end else begin
                                we      = 1'b1;
                                n_count = r_count + CW'(1);
                                if (rx_byte == nsf_pkg::LINE_END) begin
                                    n_mode = nsf_pkg::MODE_READY;
                                end
                            end
                        end
                        default: begin
                            // waiting or ready: only a start character is welcome
                            if (rx_byte == nsf_pkg::START_CHAR) begin
                                we      = 1'b1;
                                waddr   = '0;
                                wdata   = nsf_pkg::START_CHAR;
                                n_count = CW'(1);
                                n_mode  = nsf_pkg::MODE_COLLECT;
                            end else begin
                                n_mode = nsf_pkg::MODE_WAIT;
                                n_err  = 1'b1;
                            end
                        end
                    endcase
                end
                nsf_pkg::REQ_CLR_SENT: begin
                    n_count = '0;
                    n_mode  = nsf_pkg::MODE_WAIT;
                end
                nsf_pkg::REQ_CLR_FAIL: begin
                    n_err = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // a read request leaves the state alone, so the current state decides it
    assign rd_hit = (req == nsf_pkg::REQ_READ) && (r_mode == nsf_pkg::MODE_READY)
                    && (CMPW'(rd_idx) < CMPW'(r_count));
    assign re     = accept && rd_hit;

    nsf_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (CW'(rd_idx)),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= nsf_pkg::MODE_WAIT;
            r_err   <= 1'b0;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_err   <= n_err;
            r_count <= n_count;
        end
    end

    // read stage: hold while the output register is blocked
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ready <= (n_mode == nsf_pkg::MODE_READY);
            r_s1_fail  <= n_err;
            r_s1_len   <= (n_mode == nsf_pkg::MODE_READY) ? nsf_pkg::LEN_W'(n_count) : '0;
            r_s1_hit   <= rd_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move) begin
            r_out_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_vld) begin
            r_out_ready <= r_s1_ready;
            r_out_fail  <= r_s1_fail;
            r_out_len   <= r_s1_len;
            r_out_chr   <= r_s1_hit ? rdata : '0;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {1'b0, r_out_chr, r_out_len};
    assign o_m_tuser  = {r_out_fail, r_out_ready};

    // checks
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_AT)
        else $error("fill count past the buffer limit");

    a_ready_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == nsf_pkg::MODE_READY) |-> (r_count >= CW'(2)))
        else $error("ready sentence shorter than start and line end");

    a_collect_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == nsf_pkg::MODE_COLLECT) |-> (r_count != '0))
        else $error("collecting with an empty buffer");

    a_hit_ready : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_hit) |-> r_s1_ready)
        else $error("stored byte read without a ready sentence");

    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s1_move) |=> (r_s1_vld && $stable(r_s1_len) && $stable(r_s1_hit)))
        else $error("read stage lost a word under back-pressure");

endmodule

// ----- verif/nmea_sentence_framer_tb.sv -----
// nmea_sentence_framer_tb: self-checking bench for the NMEA sentence framer.
// Drives request words with random gaps and back-pressure, predicts every
// result word in a small scoreboard; depends on nsf_pkg and the framer RTL.

module nmea_sentence_framer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 800;
    localparam int unsigned QUIET_TAIL   = 100;
    localparam int unsigned STALL_LIMIT  = 1000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic       ready;
        logic       fail;
        logic [6:0] len;
        logic [7:0] rd;
    } t_framer_result;

    class t_sentence_scoreboard;
        nsf_pkg::t_frame_mode mode;
        logic                 fail;
        logic [6:0]           fill;
        logic [7:0]           line_store [nsf_pkg::BUF_DEPTH_DEF];
        t_framer_result       expected_q [$];
        int unsigned          failures;

        function new();
            mode     = nsf_pkg::MODE_WAIT;
            fail     = 1'b0;
            fill     = '0;
            failures = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Advance the framer state by one accepted word and queue its result
        function void note_word(nsf_pkg::t_req req, logic [7:0] c, logic [6:0] idx);
            t_framer_result r;
            case (req)
                nsf_pkg::REQ_BYTE: begin
                    if (mode == nsf_pkg::MODE_COLLECT) begin
                        if (int'(fill) >=
                            int'(nsf_pkg::BUF_DEPTH_DEF - nsf_pkg::END_RESERVE)) begin
                            // full: drop the byte and fall back to waiting
                            fail = 1'b1;
                            fill = '0;
                            mode = nsf_pkg::MODE_WAIT;
                        end else if (c == nsf_pkg::START_CHAR) begin
                            line_store[0] = nsf_pkg::START_CHAR;
                            fill = 7'd1;
                            fail = 1'b1;
                        end else begin
                            line_store[fill] = c;
                            fill = fill + 7'd1;
                            if (c == nsf_pkg::LINE_END)
                                mode = nsf_pkg::MODE_READY;
                        end
                    end else begin
                        // waiting and ready react alike to a byte
                        if (c == nsf_pkg::START_CHAR) begin
                            line_store[0] = nsf_pkg::START_CHAR;
                            fill = 7'd1;
                            mode = nsf_pkg::MODE_COLLECT;
                        end else begin
                            mode = nsf_pkg::MODE_WAIT;
                            fail = 1'b1;
                        end
                    end
                end
                nsf_pkg::REQ_CLR_SENT: begin
                    fill = '0;
                    mode = nsf_pkg::MODE_WAIT;
                end
                nsf_pkg::REQ_CLR_FAIL: fail = 1'b0;
                default: ;
            endcase
            r.ready = (mode == nsf_pkg::MODE_READY);
            r.fail  = fail;
            r.len   = r.ready ? fill : 7'd0;
            r.rd    = (req == nsf_pkg::REQ_READ && r.ready && idx < r.len) ?
                      line_store[idx] : 8'd0;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_framer_result got);
            t_framer_result want;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: %h", got);
                failures++;
                return;
            end
            want = expected_q.pop_front();
            if (got.ready !== want.ready) begin
                $error("sentence_ready: expected %0d, actual %0d", want.ready, got.ready);
                failures++;
            end
            if (got.fail !== want.fail) begin
                $error("fail_flag: expected %0d, actual %0d", want.fail, got.fail);
                failures++;
            end
            if (got.len !== want.len) begin
                $error("sentence_length: expected %0d, actual %0d", want.len, got.len);
                failures++;
            end
            if (got.rd !== want.rd) begin
                $error("read_char: expected %0h, actual %0h", want.rd, got.rd);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // [7:0] rx_byte, [14:8] read_index, [15] zero
    logic [1:0]  i_s_tuser  = '0;   // [1:0] req_type
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;         // [6:0] sentence_length, [14:7] read_char, [15] zero
    logic [1:0]  o_m_tuser;         // [0] sentence_ready, [1] fail_flag

    t_sentence_scoreboard sb = new();
    bit          quiet       = 1'b0;
    int unsigned words_sent  = 0;
    int unsigned idle_cycles = 0;

    nmea_sentence_framer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_framer_result got;
        if (i_rst_n && i_s_tvalid && o_s_tready)
            sb.note_word(nsf_pkg::t_req'(i_s_tuser), i_s_tdata[7:0], i_s_tdata[14:8]);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.ready = o_m_tuser[0];
            got.fail  = o_m_tuser[1];
            got.len   = o_m_tdata[6:0];
            got.rd    = o_m_tdata[14:7];
            sb.check_result(got);
        end
    end

    // Watchdog: count cycles in which neither side moves a word
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts, none once the run goes quiet
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (!i_rst_n)
                i_m_tready <= 1'b0;
            else if (stall_left != 0)
                stall_left--;
            else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_m_tready <= 1'b0;
                stall_left = $urandom_range(1, 10) - 1;
            end else
                i_m_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_word(nsf_pkg::t_req req, logic [7:0] c, logic [6:0] idx);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, idx, c};
        i_s_tuser  <= req;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
        if (words_sent >= RANDOM_ITEMS - QUIET_TAIL + 25)
            quiet = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_word(nsf_pkg::REQ_BYTE, s[i], 7'($urandom_range(0, 127)));
    endtask

    function automatic logic [7:0] body_byte();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == nsf_pkg::START_CHAR || c == nsf_pkg::LINE_END);
        return c;
    endfunction

    // Mostly short sentences; now and then one near or past the buffer limit
    task automatic random_sentence();
        int body_len;
        int span;
        logic [7:0] c;
        if ($urandom_range(0, 11) == 0)
            body_len = $urandom_range(122, 127);
        else
            body_len = $urandom_range(0, 20);
        send_word(nsf_pkg::REQ_BYTE, nsf_pkg::START_CHAR, 7'($urandom_range(0, 127)));
        for (int i = 0; i < body_len; i++) begin
            c = ($urandom_range(0, 39) == 0) ? nsf_pkg::START_CHAR : body_byte();
            send_word(nsf_pkg::REQ_BYTE, c, 7'($urandom_range(0, 127)));
        end
        if ($urandom_range(0, 9) != 0)
            send_word(nsf_pkg::REQ_BYTE, nsf_pkg::LINE_END, 7'($urandom_range(0, 127)));
        span = (body_len + 2 > 127) ? 127 : body_len + 2;
        repeat ($urandom_range(0, 4)) begin
            if ($urandom_range(0, 3) == 0)
                send_word(nsf_pkg::REQ_READ, 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, 127)));
            else
                send_word(nsf_pkg::REQ_READ, 8'($urandom_range(0, 255)),
                          7'($urandom_range(0, span)));
        end
        if ($urandom_range(0, 3) == 0)
            send_word(nsf_pkg::REQ_CLR_FAIL, 8'($urandom_range(0, 255)),
                      7'($urandom_range(0, 127)));
        if ($urandom_range(0, 5) == 0)
            send_word(nsf_pkg::REQ_CLR_SENT, 8'($urandom_range(0, 255)),
                      7'($urandom_range(0, 127)));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // read before any sentence, then a stray byte while waiting and a flag clear
        send_word(nsf_pkg::REQ_READ, 8'hFF, 7'd0);
        send_word(nsf_pkg::REQ_BYTE, 8'h41, 7'd0);
        send_word(nsf_pkg::REQ_CLR_FAIL, 8'h00, 7'h7F);
        // a clean sentence, read at both ends, just past it and at the top index
        send_word(nsf_pkg::REQ_BYTE, nsf_pkg::START_CHAR, 7'h7F);
        send_text("GP,");
        send_word(nsf_pkg::REQ_BYTE, 8'hFF, 7'd0);
        send_word(nsf_pkg::REQ_BYTE, 8'h00, 7'd0);
        send_word(nsf_pkg::REQ_BYTE, nsf_pkg::LINE_END, 7'd0);
        send_word(nsf_pkg::REQ_READ, 8'h00, 7'd0);
        send_word(nsf_pkg::REQ_READ, 8'h00, 7'd6);
        send_word(nsf_pkg::REQ_READ, 8'h00, 7'd7);
        send_word(nsf_pkg::REQ_READ, 8'hFF, 7'h7F);
        // non-start byte after a ready sentence
        send_word(nsf_pkg::REQ_BYTE, 8'h78, 7'd0);
        send_word(nsf_pkg::REQ_CLR_FAIL, 8'h00, 7'd0);
        // stray start while collecting, then finish the restarted sentence
        send_word(nsf_pkg::REQ_BYTE, nsf_pkg::START_CHAR, 7'd0);
        send_word(nsf_pkg::REQ_BYTE, 8'h61, 7'd0);
        send_word(nsf_pkg::REQ_BYTE, nsf_pkg::START_CHAR, 7'd0);
        send_word(nsf_pkg::REQ_BYTE, nsf_pkg::LINE_END, 7'd0);
        // start straight after a ready sentence, then clear it mid-collection
        send_word(nsf_pkg::REQ_BYTE, nsf_pkg::START_CHAR, 7'd0);
        send_word(nsf_pkg::REQ_CLR_SENT, 8'h00, 7'd0);
        send_word(nsf_pkg::REQ_READ, 8'h00, 7'd0);
        send_word(nsf_pkg::REQ_CLR_FAIL, 8'h00, 7'd0);

        while (words_sent < RANDOM_ITEMS + 25) begin
            if ($urandom_range(0, 9) < 7)
                random_sentence();
            else
                repeat ($urandom_range(1, 4))
                    send_word(nsf_pkg::t_req'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)),
                              7'($urandom_range(0, 127)));
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/nsf_pkg.sv
rtl/core/nsf_ram.sv
rtl/core/nmea_sentence_framer.sv
verif/nmea_sentence_framer_tb.sv
